[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define SATH_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds while reset is asserted.
`define SATH_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

[sv/sath_pkg.sv]
// ----------------------------------------------------------------------------
// sath_pkg
// Types, constants and functions of the split archive tail checker.
// ----------------------------------------------------------------------------
package sath_pkg;

    localparam logic [5:0]  HdrLen      = 6'd32;
    localparam logic [5:0]  SigLen      = 6'd6;
    localparam logic [5:0]  CrcPosFirst = 6'd8;
    localparam logic [5:0]  CrcFirst    = 6'd12;
    localparam logic [5:0]  SizeFirst   = 6'd20;
    localparam logic [5:0]  SizeEnd     = 6'd28;
    localparam logic [31:0] CrcInit     = 32'hFFFF_FFFF;
    localparam logic [31:0] CrcPoly     = 32'hEDB8_8320;
    localparam logic [63:0] AllOnes64   = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        V_TAIL_MISSING = 3'd0,
        V_COMPLETE     = 3'd1,
        V_BAD_SIG      = 3'd2,
        V_CRC_MISMATCH = 3'd3,
        V_SHORT_HDR    = 3'd4,
        V_OVERFLOW     = 3'd5
    } t_verdict;

    typedef struct packed {
        logic        done;
        logic        sig_ok;
        logic        crc_ok;
        logic [63:0] offset;
        logic [63:0] size;
    } t_hdr_stat;

    function automatic logic [7:0] sig_byte(logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h37;
            3'd1:    b = 8'h7A;
            3'd2:    b = 8'hBC;
            3'd3:    b = 8'hAF;
            3'd4:    b = 8'h27;
            3'd5:    b = 8'h1C;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = {1'b0, c[31:1]} ^ (c[0] ? CrcPoly : 32'd0);
        end
        return c;
    endfunction

endpackage

[sv/sath_ifs.sv]
// ----------------------------------------------------------------------------
// sath_ifs
// Valid/ready channels for input items and for results.
// ----------------------------------------------------------------------------
interface sath_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [7:0]  header_byte;
    logic [63:0] volume_size;
    logic        last_volume;

    modport source (output valid, func, header_byte, volume_size, last_volume,
                     input ready);
    modport sink   (input valid, func, header_byte, volume_size, last_volume,
                     output ready);
endinterface

interface sath_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [63:0] required_size;
    logic [63:0] received_size;

    modport source (output valid, verdict, required_size, received_size,
                     input ready);
    modport sink   (input valid, verdict, required_size, received_size,
                     output ready);
endinterface

[sv/sath_hdr.sv]
// ----------------------------------------------------------------------------
// sath_hdr
// Start header collector: signature check, CRC-32 and field assembly.
// ----------------------------------------------------------------------------
module sath_hdr (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [7:0]           i_byte,
    input  logic                 i_clear,
    output sath_pkg::t_hdr_stat  o_stat
);

    logic [5:0]  r_count, n_count;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_stored, n_stored;
    logic        r_sig_ok, n_sig_ok;
    logic [63:0] r_offset, n_offset;
    logic [63:0] r_size, n_size;
    logic [2:0]  rel;

    assign rel = r_count[2:0] - sath_pkg::CrcFirst[2:0];

    always_comb begin
        n_count  = r_count;
        n_crc    = r_crc;
        n_stored = r_stored;
        n_sig_ok = r_sig_ok;
        n_offset = r_offset;
        n_size   = r_size;
        if (i_en && (r_count < sath_pkg::HdrLen)) begin
            n_count = r_count + 6'd1;
            if (r_count < sath_pkg::SigLen) begin
                if (i_byte != sath_pkg::sig_byte(r_count[2:0])) begin
                    n_sig_ok = 1'b0;
                end
            end else if ((r_count >= sath_pkg::CrcPosFirst) &&
                         (r_count < sath_pkg::CrcFirst)) begin
                n_stored[{r_count[1:0], 3'b000} +: 8] = i_byte;
            end
            if (r_count >= sath_pkg::CrcFirst) begin
                n_crc = sath_pkg::crc_byte(r_crc, i_byte);
                if (r_count < sath_pkg::SizeFirst) begin
                    n_offset[{rel, 3'b000} +: 8] = i_byte;
                end else if (r_count < sath_pkg::SizeEnd) begin
                    n_size[{rel, 3'b000} +: 8] = i_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_count  <= '0;
            r_crc    <= sath_pkg::CrcInit;
            r_stored <= '0;
            r_sig_ok <= 1'b1;
            r_offset <= '0;
            r_size   <= '0;
        end else begin
            r_count  <= n_count;
            r_crc    <= n_crc;
            r_stored <= n_stored;
            r_sig_ok <= n_sig_ok;
            r_offset <= n_offset;
            r_size   <= n_size;
        end
    end

    assign o_stat.done   = (r_count == sath_pkg::HdrLen);
    assign o_stat.sig_ok = r_sig_ok;
    assign o_stat.crc_ok = (~r_crc == r_stored);
    assign o_stat.offset = r_offset;
    assign o_stat.size   = r_size;

endmodule

[sv/sath_vol.sv]
// ----------------------------------------------------------------------------
// sath_vol
// Volume size accumulator and verdict logic.
// ----------------------------------------------------------------------------
module sath_vol (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [63:0]          i_size,
    input  logic                 i_last,
    input  sath_pkg::t_hdr_stat  i_stat,
    output sath_pkg::t_verdict   o_verdict,
    output logic [63:0]          o_expected,
    output logic [63:0]          o_available,
    output logic                 o_clear
);

    logic [63:0] r_sum, n_sum;
    logic        r_ovf, n_ovf;
    logic [64:0] sum_ext;
    logic [64:0] exp1;
    logic [64:0] exp2;
    logic        hdr_ovf;

    assign sum_ext = {1'b0, r_sum} + {1'b0, i_size};
    assign n_ovf   = r_ovf | sum_ext[64];
    assign n_sum   = n_ovf ? sath_pkg::AllOnes64 : sum_ext[63:0];

    assign exp1    = {1'b0, i_stat.offset} + {59'd0, sath_pkg::HdrLen};
    assign exp2    = {1'b0, exp1[63:0]} + {1'b0, i_stat.size};
    assign hdr_ovf = exp1[64] | exp2[64];

    always_comb begin
        o_expected = '0;
        if (!i_stat.done) begin
            o_verdict = sath_pkg::V_SHORT_HDR;
        end else if (!i_stat.sig_ok) begin
            o_verdict = sath_pkg::V_BAD_SIG;
        end else if (!i_stat.crc_ok) begin
            o_verdict = sath_pkg::V_CRC_MISMATCH;
        end else if (hdr_ovf) begin
            o_verdict = sath_pkg::V_OVERFLOW;
        end else begin
            o_expected = exp2[63:0];
            if (n_ovf) begin
                o_verdict = sath_pkg::V_OVERFLOW;
            end else if (n_sum < exp2[63:0]) begin
                o_verdict = sath_pkg::V_TAIL_MISSING;
            end else begin
                o_verdict = sath_pkg::V_COMPLETE;
            end
        end
    end

    assign o_available = n_sum;
    assign o_clear     = i_en && i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_clear) begin
            r_sum <= '0;
            r_ovf <= 1'b0;
        end else if (i_en) begin
            r_sum <= n_sum;
            r_ovf <= n_ovf;
        end
    end

endmodule

[sv/split_archive_tail_checker_top.sv]
// ----------------------------------------------------------------------------
// split_archive_tail_checker_top
// Checks a split archive start header and the volume sizes against it.
//
//   channel    | dir | payload
//   -----------+-----+------------------------------------------------------
//   i_in_ch    | in  | func, header_byte, volume_size, last_volume
//   o_res_ch   | out | verdict, required_size, received_size
//
// One item is taken per clock unless a stalled result holds it back. The input
// register feeds header, CRC and 64-bit sum logic, then the result register.
// Synchronous active-low reset clears both valid bits and all archive state.
// A stalled result holds the pipeline; the input register still fills once.
// ----------------------------------------------------------------------------
module split_archive_tail_checker_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sath_in_if.sink         i_in_ch,
    sath_out_if.source      o_res_ch
);

    logic                 r_in_valid;
    logic                 r_func;
    logic [7:0]           r_byte;
    logic [63:0]          r_vsize;
    logic                 r_last;
    logic                 r_out_valid;
    sath_pkg::t_verdict   r_verdict;
    logic [63:0]          r_expected;
    logic [63:0]          r_available;

    logic                 adv;
    logic                 proc;
    sath_pkg::t_hdr_stat  hdr_stat;
    sath_pkg::t_verdict   verdict;
    logic [63:0]          expected;
    logic [63:0]          available;
    logic                 clear;

    assign adv            = !r_out_valid || o_res_ch.ready;
    assign proc           = r_in_valid && adv;
    assign i_in_ch.ready  = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_in_ch.ready) begin
            r_func  <= i_in_ch.func;
            r_byte  <= i_in_ch.header_byte;
            r_vsize <= i_in_ch.volume_size;
            r_last  <= i_in_ch.last_volume;
        end
    end

    sath_hdr u_hdr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (proc && !r_func),
        .i_byte  (r_byte),
        .i_clear (clear),
        .o_stat  (hdr_stat)
    );

    sath_vol u_vol (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (proc && r_func),
        .i_size      (r_vsize),
        .i_last      (r_last),
        .i_stat      (hdr_stat),
        .o_verdict   (verdict),
        .o_expected  (expected),
        .o_available (available),
        .o_clear     (clear)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= clear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (clear) begin
            r_verdict   <= verdict;
            r_expected  <= expected;
            r_available <= available;
        end
    end

    assign o_res_ch.valid         = r_out_valid;
    assign o_res_ch.verdict       = r_verdict;
    assign o_res_ch.required_size = r_expected;
    assign o_res_ch.received_size = r_available;

endmodule

[sv/sath_checker.sv]
// ----------------------------------------------------------------------------
// sath_checker
// Port-level assertions on the split archive tail checker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sath_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [2:0]  i_verdict,
    input logic [63:0] i_expected,
    input logic [63:0] i_available
);

    logic         res_wait;
    logic [130:0] res_data;
    logic         no_size_verdict;
    logic         res_complete;
    logic         res_missing;

    assign res_wait        = i_res_valid && !i_res_ready;
    assign res_data        = {i_verdict, i_expected, i_available};
    assign no_size_verdict = (i_verdict == sath_pkg::V_BAD_SIG) ||
                             (i_verdict == sath_pkg::V_CRC_MISMATCH) ||
                             (i_verdict == sath_pkg::V_SHORT_HDR);
    assign res_complete    = i_res_valid && (i_verdict == sath_pkg::V_COMPLETE);
    assign res_missing     = i_res_valid && (i_verdict == sath_pkg::V_TAIL_MISSING);

    `SATH_ASSERT(a_res_hold, i_clk, i_rst_n, res_wait |=> i_res_valid && $stable(res_data))
    `SATH_ASSERT(a_no_expected, i_clk, i_rst_n, i_res_valid && no_size_verdict |-> !(|i_expected))
    `SATH_ASSERT(a_complete, i_clk, i_rst_n, res_complete |-> i_available >= i_expected)
    `SATH_ASSERT(a_tail_missing, i_clk, i_rst_n, res_missing |-> i_available < i_expected)
    `SATH_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_res_valid)

endmodule

bind split_archive_tail_checker_top sath_checker u_sath_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res_ch.valid),
    .i_res_ready (o_res_ch.ready),
    .i_verdict   (o_res_ch.verdict),
    .i_expected  (o_res_ch.required_size),
    .i_available (o_res_ch.received_size)
);

[tb/tb_split_archive_tail_checker_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_split_archive_tail_checker_top
// Streams start headers and volume sizes into the split archive tail checker
// and compares every verdict with an in-bench model of the header, CRC and
// volume sum checks, under random idling and long result back-pressure.
// ----------------------------------------------------------------------------
module tb_split_archive_tail_checker_top;

    localparam int          ClkHalf        = 6;
    localparam int          IdlePct        = 18;
    localparam int          HoldCycles     = 150;
    localparam int          TailCycles     = 8;
    localparam int          CycleLimit     = 300000;
    localparam int          RandomItems    = 260;
    localparam logic [63:0] TopBit         = 64'h8000_0000_0000_0000;
    localparam logic [47:0] Sig7z          = 48'h1C27_AFBC_7A37;

    typedef struct packed {
        logic        func;
        logic [7:0]  hbyte;
        logic [63:0] vsize;
        logic        last;
    } t_arc_item;

    typedef struct packed {
        sath_pkg::t_verdict verdict;
        logic [63:0]        need;
        logic [63:0]        avail;
    } t_tail_verdict;

    typedef enum int {
        K_COMPLETE,
        K_TAIL_MISSING,
        K_EXACT_FIT,
        K_BAD_SIG,
        K_BAD_CRC,
        K_SHORT,
        K_HDR_OVERFLOW,
        K_SUM_OVERFLOW,
        K_EXTRA_BYTES,
        K_MIXED,
        K_NOISE
    } t_arc_kind;

    logic i_clk;
    logic i_rst_n;

    sath_in_if  in_ch ();
    sath_out_if res_ch ();

    split_archive_tail_checker_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_res_ch (res_ch)
    );

    logic [5:0]    hdr_count;
    logic [31:0]   crc_run;
    logic [31:0]   crc_field;
    logic          sig_good;
    logic [63:0]   next_off;
    logic [63:0]   next_len;
    logic [63:0]   vol_total;
    logic          vol_wrapped;
    t_tail_verdict pending_verdicts [$];
    t_tail_verdict want_verdict;

    int mismatches    = 0;
    int items_used    = 0;
    int verdict_count = 0;
    int cycle_count   = 0;
    bit no_idle       = 1'b0;
    bit hold_req      = 1'b0;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] vol_noise();
        return $urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 999));
    endfunction

    function automatic logic [31:0] crc32_byte(logic [31:0] c, logic [7:0] b);
        c = c ^ {24'd0, b};
        repeat (8) begin
            c = c[0] ? ((c >> 1) ^ sath_pkg::CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

    function automatic void archive_clear();
        hdr_count   = '0;
        crc_run     = sath_pkg::CrcInit;
        crc_field   = '0;
        sig_good    = 1'b1;
        next_off    = '0;
        next_len    = '0;
        vol_total   = '0;
        vol_wrapped = 1'b0;
    endfunction

    function automatic void archive_take(t_arc_item it);
        t_tail_verdict v;
        logic [65:0]   need_wide;
        logic [64:0]   sum_wide;
        int            idx;
        idx = int'(hdr_count);
        if (!it.func) begin
            if (idx < sath_pkg::HdrLen) begin
                if (idx < sath_pkg::SigLen) begin
                    if (it.hbyte != Sig7z[8*idx +: 8]) sig_good = 1'b0;
                end else if (idx >= sath_pkg::CrcPosFirst && idx < sath_pkg::CrcFirst) begin
                    crc_field[8*(idx - sath_pkg::CrcPosFirst) +: 8] = it.hbyte;
                end
                if (idx >= sath_pkg::CrcFirst) begin
                    crc_run = crc32_byte(crc_run, it.hbyte);
                    if (idx < sath_pkg::SizeFirst) begin
                        next_off[8*(idx - sath_pkg::CrcFirst) +: 8] = it.hbyte;
                    end else if (idx < sath_pkg::SizeEnd) begin
                        next_len[8*(idx - sath_pkg::SizeFirst) +: 8] = it.hbyte;
                    end
                end
                hdr_count = hdr_count + 6'd1;
            end
            return;
        end
        sum_wide = {1'b0, vol_total} + {1'b0, it.vsize};
        if (vol_wrapped || sum_wide[64]) begin
            vol_wrapped = 1'b1;
            vol_total   = sath_pkg::AllOnes64;
        end else begin
            vol_total = sum_wide[63:0];
        end
        if (!it.last) return;
        v.need = '0;
        if (hdr_count < sath_pkg::HdrLen) begin
            v.verdict = sath_pkg::V_SHORT_HDR;
        end else if (!sig_good) begin
            v.verdict = sath_pkg::V_BAD_SIG;
        end else if (~crc_run != crc_field) begin
            v.verdict = sath_pkg::V_CRC_MISMATCH;
        end else begin
            need_wide = {2'b0, next_off} + {2'b0, next_len} + 66'(sath_pkg::HdrLen);
            if (need_wide[65:64] != 2'b00) begin
                v.verdict = sath_pkg::V_OVERFLOW;
            end else begin
                v.need = need_wide[63:0];
                if (vol_wrapped) begin
                    v.verdict = sath_pkg::V_OVERFLOW;
                end else if (vol_total < v.need) begin
                    v.verdict = sath_pkg::V_TAIL_MISSING;
                end else begin
                    v.verdict = sath_pkg::V_COMPLETE;
                end
            end
        end
        v.avail = vol_total;
        pending_verdicts.push_back(v);
        verdict_count++;
        archive_clear();
    endfunction

    function automatic t_arc_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return K_COMPLETE;
        if (r < 40) return K_TAIL_MISSING;
        if (r < 45) return K_EXACT_FIT;
        if (r < 55) return K_BAD_SIG;
        if (r < 65) return K_BAD_CRC;
        if (r < 75) return K_SHORT;
        if (r < 80) return K_HDR_OVERFLOW;
        if (r < 85) return K_SUM_OVERFLOW;
        if (r < 90) return K_EXTRA_BYTES;
        if (r < 95) return K_MIXED;
        return K_NOISE;
    endfunction

    task automatic send_item(input t_arc_item it);
        while (!no_idle && $urandom_range(0, 99) < IdlePct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.func        <= it.func;
        in_ch.header_byte <= it.hbyte;
        in_ch.volume_size <= it.vsize;
        in_ch.last_volume <= it.last;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        if (it.func || hdr_count < sath_pkg::HdrLen) items_used++;
        archive_take(it);
    endtask

    task automatic send_header_byte(input logic [7:0] b);
        t_arc_item it;
        it.func  = 1'b0;
        it.hbyte = b;
        it.vsize = rand64();
        it.last  = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    task automatic send_volume(input logic [63:0] size, input logic last);
        t_arc_item it;
        it.func  = 1'b1;
        it.hbyte = 8'($urandom_range(0, 255));
        it.vsize = size;
        it.last  = last;
        send_item(it);
    endtask

    task automatic drain_verdicts();
        in_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);
    endtask

    task automatic run_archive(input t_arc_kind kind);
        logic [7:0]  hdr [32];
        logic [63:0] parts [$];
        logic [63:0] off;
        logic [63:0] len;
        logic [63:0] need;
        logic [63:0] remaining;
        logic [63:0] part;
        logic [31:0] crc;
        int          n_bytes;
        int          n_extra;
        int          n_vols;
        int          n_noise;
        int          pos;
        if (kind == K_NOISE) begin
            n_noise = $urandom_range(1, 12);
            repeat (n_noise) begin
                if ($urandom_range(0, 1)) begin
                    send_header_byte(8'($urandom_range(0, 255)));
                end else begin
                    send_volume(vol_noise(), $urandom_range(0, 9) == 0);
                end
            end
            send_volume(vol_noise(), 1'b1);
            return;
        end
        len = 64'($urandom_range(0, 300));
        off = 64'($urandom_range(0, 5000));
        if (kind == K_EXACT_FIT) begin
            off = sath_pkg::AllOnes64 - 64'd32 - len;
        end else if (kind == K_HDR_OVERFLOW) begin
            if ($urandom_range(0, 1)) begin
                off = sath_pkg::AllOnes64 - 64'd31 - len;
            end else begin
                off = rand64() | TopBit;
                len = rand64() | TopBit;
            end
        end
        for (int i = 0; i < 32; i++) hdr[i] = 8'($urandom_range(0, 255));
        for (int i = 0; i < 6; i++) hdr[i] = Sig7z[8*i +: 8];
        for (int i = 0; i < 8; i++) begin
            hdr[12 + i] = off[8*i +: 8];
            hdr[20 + i] = len[8*i +: 8];
        end
        crc = sath_pkg::CrcInit;
        for (int i = 12; i < 32; i++) crc = crc32_byte(crc, hdr[i]);
        crc = ~crc;
        for (int i = 0; i < 4; i++) hdr[8 + i] = crc[8*i +: 8];
        if (kind == K_BAD_SIG) begin
            pos = $urandom_range(0, 5);
            hdr[pos] = hdr[pos] ^ (8'd1 << $urandom_range(0, 7));
        end else if (kind == K_BAD_CRC) begin
            pos = $urandom_range(8, 31);
            hdr[pos] = hdr[pos] ^ (8'd1 << $urandom_range(0, 7));
        end
        n_bytes = (kind == K_SHORT) ? int'($urandom_range(0, 31)) : 32;
        n_extra = (kind == K_EXTRA_BYTES) ? int'($urandom_range(1, 4)) : 0;

        need = 64'd32 + off + len;
        if (kind == K_TAIL_MISSING) begin
            remaining = need - 64'd1 - 64'($urandom_range(0, 31));
        end else if (sath_pkg::AllOnes64 - need < 64'd2) begin
            remaining = need;
        end else begin
            remaining = need + 64'($urandom_range(0, 2));
        end
        n_vols = $urandom_range(1, 4);
        repeat (n_vols - 1) begin
            part = (remaining == 0) ? 64'd0 : rand64() % remaining;
            parts.push_back(part);
            remaining = remaining - part;
        end
        parts.push_back(remaining);
        if (kind == K_SUM_OVERFLOW) begin
            parts.delete();
            parts.push_back(rand64() | TopBit);
            parts.push_back(rand64() | TopBit);
            if ($urandom_range(0, 1)) parts.push_back(vol_noise());
        end

        for (int b = 0; b < n_bytes + n_extra; b++) begin
            if (kind == K_MIXED && parts.size() > 1 && $urandom_range(0, 5) == 0) begin
                part = parts.pop_front();
                send_volume(part, 1'b0);
            end
            send_header_byte((b < 32) ? hdr[b] : 8'($urandom_range(0, 255)));
        end
        while (parts.size() != 0) begin
            part = parts.pop_front();
            send_volume(part, parts.size() == 0);
        end
    endtask

    task automatic test_directed_edges();
        send_volume(64'd0, 1'b1);
        send_volume(sath_pkg::AllOnes64, 1'b0);
        send_volume(64'd1, 1'b1);
        send_volume(sath_pkg::AllOnes64, 1'b1);
        send_header_byte(8'h00);
        send_header_byte(8'hFF);
        send_header_byte(8'h37);
        send_volume(TopBit, 1'b0);
        send_volume(TopBit, 1'b1);
        send_header_byte(8'h37);
        send_header_byte(8'h7A);
        send_header_byte(8'hBC);
        send_volume(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        drain_verdicts();
    endtask

    task automatic test_each_archive_kind();
        for (int k = K_COMPLETE; k <= K_NOISE; k++) run_archive(t_arc_kind'(k));
        drain_verdicts();
    endtask

    task automatic test_result_backpressure();
        hold_req = 1'b1;
        no_idle  = 1'b1;
        repeat (20) send_volume(64'($urandom_range(0, 99)), 1'b1);
        no_idle = 1'b0;
        drain_verdicts();
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (4) run_archive(pick_kind());
        no_idle = 1'b0;
        drain_verdicts();
    endtask

    task automatic test_random_archives();
        int first_items;
        first_items = items_used;
        while (items_used - first_items < RandomItems) begin
            run_archive(pick_kind());
        end
        drain_verdicts();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #ClkHalf i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CycleLimit);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
            end else begin
                res_ch.ready <= no_idle || ($urandom_range(0, 99) >= IdlePct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result, verdict %0d required_size %0h received_size %0h",
                         $time, res_ch.verdict, res_ch.required_size, res_ch.received_size);
                mismatches++;
            end else begin
                want_verdict = pending_verdicts.pop_front();
                if (res_ch.verdict !== want_verdict.verdict) begin
                    $display("%0t: verdict mismatch, expected %0d, actual %0d",
                             $time, want_verdict.verdict, res_ch.verdict);
                    mismatches++;
                end
                if (res_ch.required_size !== want_verdict.need) begin
                    $display("%0t: required_size mismatch, expected %0h, actual %0h",
                             $time, want_verdict.need, res_ch.required_size);
                    mismatches++;
                end
                if (res_ch.received_size !== want_verdict.avail) begin
                    $display("%0t: received_size mismatch, expected %0h, actual %0h",
                             $time, want_verdict.avail, res_ch.received_size);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.func        <= 1'b0;
        in_ch.header_byte <= '0;
        in_ch.volume_size <= '0;
        in_ch.last_volume <= 1'b0;
        archive_clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_each_archive_kind();
        test_result_backpressure();
        test_back_to_back();
        test_random_archives();

        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
